>>> rtl/core/mbe_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time block.
package mbe_pkg;

    localparam int Q_W         = 32;
    localparam int PIX_W       = 12;
    localparam int DIM_W       = 13;
    localparam int COUNT_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_MAG_W  = 45;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MIN_R      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_R      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_I      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_I      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 3'd6;

    localparam logic [Q_W-1:0]     RST_MIN_R      = 32'hE000_0000;
    localparam logic [Q_W-1:0]     RST_MAX_R      = 32'h1000_0000;
    localparam logic [Q_W-1:0]     RST_MIN_I      = 32'hE800_0000;
    localparam logic [Q_W-1:0]     RST_MAX_I      = 32'h1800_0000;
    localparam logic [DIM_W-1:0]   RST_IMG_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_IMG_HEIGHT = 13'd480;
    localparam logic [COUNT_W-1:0] RST_ITER_LIMIT = 16'd255;

    // 4.0 at Q8.56
    localparam logic [63:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;
    localparam logic [Q_W-1:0] Q_MAXV = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MINV = 32'h8000_0000;

    typedef struct packed {
        logic [Q_W-1:0]     min_r;
        logic [Q_W-1:0]     max_r;
        logic [Q_W-1:0]     min_i;
        logic [Q_W-1:0]     max_i;
        logic [DIM_W-1:0]   image_width;
        logic [DIM_W-1:0]   image_height;
        logic [COUNT_W-1:0] iteration_limit;
    } mbe_cfg_t;

    typedef struct packed {
        logic [Q_W-1:0] cr;
        logic [Q_W-1:0] ci;
    } mbe_point_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mbe_qstat_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PROD,
        F_DIV,
        F_SUM,
        F_PUSH
    } mbe_fstate_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_UPD
    } mbe_bstate_t;

    // Clamp a wide signed value into the Q4.28 range.
    function automatic logic [Q_W-1:0] sat_q(input logic signed [63:0] v);
        logic [Q_W-1:0] r;
        if ((&v[63:31]) || (~|v[63:31]))
        begin
            r = v[31:0];
        end
        else if (v[63])
        begin
            r = Q_MINV;
        end
        else
        begin
            r = Q_MAXV;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/mbe_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module mbe_div
    import mbe_pkg::*;
#(
    parameter int N_W = 45,
    parameter int D_W = 13
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           done,
    output logic [N_W-1:0] quotient
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             done_reg, done_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [N_W-1:0]   quo_reg, quo_next;

    logic [D_W:0] trial;
    logic [D_W:0] trial_diff;
    logic         take;

    always_comb
    begin
        trial      = {rem_reg, quo_reg[N_W-1]};
        trial_diff = trial - {1'b0, divisor};
        take       = (trial >= {1'b0, divisor});
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(N_W);
            rem_next = '0;
            quo_next = dividend;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            rem_next  = take ? trial_diff[D_W-1:0] : trial[D_W-1:0];
            quo_next  = {quo_reg[N_W-2:0], take};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/core/mbe_queue.sv
// Short queue of mapped points between the front and the back.
module mbe_queue
    import mbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  mbe_point_t push_data,
    input  logic       pop,
    output mbe_point_t pop_data,
    output mbe_qstat_t status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    mbe_point_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data     = entry_reg[rd_ptr_reg];
    assign status.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (cnt_reg == '0);

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != CNT_W'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (cnt_reg != '0))
        else $error("queue pop while empty");

endmodule

>>> rtl/core/mbe_front.sv
// Front end: accepts a pixel and maps it to a point of the complex plane.
module mbe_front
    import mbe_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [PIX_W-1:0] pixel_x,
    input  logic [PIX_W-1:0] pixel_y,
    input  mbe_cfg_t         cfg,
    input  mbe_qstat_t       qstat,
    output logic             push,
    output mbe_point_t       point
);

    localparam int DIV_W = $clog2(MAX_DIM + 1);

    mbe_fstate_t      state_reg, state_next;
    logic             axis_reg, axis_next;
    logic [PIX_W-1:0] px_reg, px_next;
    logic [PIX_W-1:0] py_reg, py_next;
    logic             neg_reg, neg_next;
    logic [Q_W-1:0]   cr_reg, cr_next;
    logic [Q_W-1:0]   ci_reg, ci_next;

    logic [PIX_W-1:0]      pix;
    logic [Q_W-1:0]        lo;
    logic [Q_W-1:0]        hi;
    logic [DIM_W-1:0]      dim;
    logic [31:0]           dim_clamped;
    logic signed [32:0]    range_val;
    logic signed [45:0]    prod;
    logic signed [45:0]    prod_neg;
    logic [PROD_MAG_W-1:0] prod_mag;
    logic signed [45:0]    quo_ext;
    logic signed [45:0]    offset;
    logic signed [63:0]    sum;
    logic [Q_W-1:0]        mapped;

    logic                  div_start;
    logic                  div_done;
    logic [PROD_MAG_W-1:0] div_quotient;

    always_comb
    begin
        pix = axis_reg ? py_reg : px_reg;
        lo  = axis_reg ? cfg.min_i : cfg.min_r;
        hi  = axis_reg ? cfg.max_i : cfg.max_r;
        dim = axis_reg ? cfg.image_height : cfg.image_width;

        if (dim == '0)
        begin
            dim_clamped = 32'd1;
        end
        else if ({19'b0, dim} > 32'(MAX_DIM))
        begin
            dim_clamped = 32'(MAX_DIM);
        end
        else
        begin
            dim_clamped = {19'b0, dim};
        end

        range_val = $signed({hi[Q_W-1], hi}) - $signed({lo[Q_W-1], lo});
        prod      = range_val * $signed({1'b0, pix});
        prod_neg  = -prod;
        prod_mag  = prod[45] ? prod_neg[PROD_MAG_W-1:0] : prod[PROD_MAG_W-1:0];

        // truncation toward zero: divide the magnitude, then restore the sign
        quo_ext = $signed({1'b0, div_quotient});
        offset  = neg_reg ? -quo_ext : quo_ext;
        sum     = $signed({{32{lo[Q_W-1]}}, lo}) + $signed({{18{offset[45]}}, offset});
        mapped  = sat_q(sum);
    end

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        px_next    = px_reg;
        py_next    = py_reg;
        neg_next   = neg_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        div_start  = 1'b0;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel_x;
                    py_next    = pixel_y;
                    axis_next  = 1'b0;
                    state_next = F_PROD;
                end
            end
            F_PROD:
            begin
                div_start  = 1'b1;
                neg_next   = prod[45];
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    state_next = F_SUM;
                end
            end
            F_SUM:
            begin
                if (!axis_reg)
                begin
                    cr_next    = mapped;
                    axis_next  = 1'b1;
                    state_next = F_PROD;
                end
                else
                begin
                    ci_next    = mapped;
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!qstat.full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            axis_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= px_next;
        py_reg  <= py_next;
        neg_reg <= neg_next;
        cr_reg  <= cr_next;
        ci_reg  <= ci_next;
    end

    mbe_div #(
        .N_W (PROD_MAG_W),
        .D_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag),
        .divisor  (dim_clamped[DIV_W-1:0]),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign busy     = (state_reg != F_IDLE);
    assign point.cr = cr_reg;
    assign point.ci = ci_reg;

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == F_DIV))
        else $error("divider finished outside the divide phase");

endmodule

>>> rtl/core/mbe_back.sv
// Back end: iterates z = z*z + c for one queued point and reports the count.
module mbe_back
    import mbe_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  mbe_qstat_t         qstat,
    input  mbe_point_t         point,
    output logic               pop,
    input  logic [COUNT_W-1:0] iteration_limit,
    output logic               done,
    output logic [COUNT_W-1:0] escape_count
);

    mbe_bstate_t        state_reg, state_next;
    logic               done_reg, done_next;
    logic [COUNT_W-1:0] n_reg, n_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic signed [31:0] cr_reg, cr_next;
    logic signed [31:0] ci_reg, ci_next;
    logic signed [31:0] zr_reg, zr_next;
    logic signed [31:0] zi_reg, zi_next;
    logic signed [63:0] rr_reg, rr_next;
    logic signed [63:0] ii_reg, ii_next;
    logic signed [63:0] ri_reg, ri_next;

    logic               escaped;
    logic signed [63:0] diff;
    logic signed [63:0] nr_sum;
    logic signed [63:0] ni_sum;

    always_comb
    begin
        escaped = ($unsigned(rr_reg) + $unsigned(ii_reg)) >= ESCAPE_Q56;
        diff    = rr_reg - ii_reg;
        nr_sum  = (diff >>> 28) + $signed({{32{cr_reg[31]}}, cr_reg});
        ni_sum  = (ri_reg >>> 27) + $signed({{32{ci_reg[31]}}, ci_reg});
    end

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        n_next     = n_reg;
        count_next = count_reg;
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        rr_next    = rr_reg;
        ii_next    = ii_reg;
        ri_next    = ri_reg;
        pop        = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    cr_next    = $signed(point.cr);
                    ci_next    = $signed(point.ci);
                    zr_next    = '0;
                    zi_next    = '0;
                    n_next     = '0;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                if (n_reg >= iteration_limit)
                begin
                    done_next  = 1'b1;
                    count_next = n_reg;
                    state_next = B_IDLE;
                end
                else
                begin
                    rr_next    = zr_reg * zr_reg;
                    ii_next    = zi_reg * zi_reg;
                    ri_next    = zr_reg * zi_reg;
                    state_next = B_UPD;
                end
            end
            B_UPD:
            begin
                if (escaped)
                begin
                    done_next  = 1'b1;
                    count_next = n_reg;
                    state_next = B_IDLE;
                end
                else
                begin
                    zr_next    = $signed(sat_q(nr_sum));
                    zi_next    = $signed(sat_q(ni_sum));
                    n_next     = n_reg + 1'b1;
                    state_next = B_MUL;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        count_reg <= count_next;
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        rr_reg    <= rr_next;
        ii_reg    <= ii_next;
        ri_reg    <= ri_next;
    end

    assign done         = done_reg;
    assign escape_count = count_reg;

    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (count_reg <= iteration_limit))
        else $error("escape count above the iteration limit");

    a_upd_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_UPD) |-> ($past(state_reg) == B_MUL))
        else $error("update phase entered without fresh products");

endmodule

>>> rtl/core/mandelbrot_escape_iteration.sv
// Top level of the Mandelbrot escape-time engine: config registers, front, queue, back.
// Each pixel is mapped with two 45-step divides, one per axis, and then pushed into the queue;
//   the back pops it when idle and strobes done at the limit or on escape.
// The front maps the next pixel while the multiply/update loop of the iterator runs, and
//   holds it with busy high while the queue is full.
// Reset (rst_n low, asynchronous) empties the queue, idles both halves and loads
//   the default view; done is a one-cycle strobe that the receiver cannot stall.
module mandelbrot_escape_iteration
    import mbe_pkg::*;
#(
    parameter int MAX_DIM = 4096
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel command
    input  logic                  start,
    output logic                  busy,
    input  logic [PIX_W-1:0]      pixel_x,
    input  logic [PIX_W-1:0]      pixel_y,
    // result strobe
    output logic                  done,
    output logic [COUNT_W-1:0]    escape_count,
    // register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers. Writes must arrive only while the engine is idle; the block
    // does not enforce this, and both halves read them live without a shadow copy.
    mbe_cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MIN_R:      cfg_next.min_r           = cfg_data;
                REG_MAX_R:      cfg_next.max_r           = cfg_data;
                REG_MIN_I:      cfg_next.min_i           = cfg_data;
                REG_MAX_I:      cfg_next.max_i           = cfg_data;
                REG_IMG_WIDTH:  cfg_next.image_width     = cfg_data[DIM_W-1:0];
                REG_IMG_HEIGHT: cfg_next.image_height    = cfg_data[DIM_W-1:0];
                REG_ITER_LIMIT: cfg_next.iteration_limit = cfg_data[COUNT_W-1:0];
                default:        cfg_next = cfg_reg;  // drop writes to unknown indexes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_r           <= RST_MIN_R;
            cfg_reg.max_r           <= RST_MAX_R;
            cfg_reg.min_i           <= RST_MIN_I;
            cfg_reg.max_i           <= RST_MAX_I;
            cfg_reg.image_width     <= RST_IMG_WIDTH;
            cfg_reg.image_height    <= RST_IMG_HEIGHT;
            cfg_reg.iteration_limit <= RST_ITER_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register writes always complete in one transfer.
    assign cfg_ready = 1'b1;

    mbe_point_t front_point;
    mbe_point_t back_point;
    mbe_qstat_t qstat;
    logic       q_push;
    logic       q_pop;

    // Front: take a pixel when idle, map it to c, hand it to the queue.
    // busy stays high until the mapped point is in the queue.
    mbe_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pixel_x (pixel_x),
        .pixel_y (pixel_y),
        .cfg     (cfg_reg),
        .qstat   (qstat),
        .push    (q_push),
        .point   (front_point)
    );

    // Queue: lets the front map the next pixel while the back still iterates.
    mbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_point),
        .pop       (q_pop),
        .pop_data  (back_point),
        .status    (qstat)
    );

    // Back: iterate z = z*z + c and strobe the count out on done.
    mbe_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .qstat           (qstat),
        .point           (back_point),
        .pop             (q_pop),
        .iteration_limit (cfg_reg.iteration_limit),
        .done            (done),
        .escape_count    (escape_count)
    );

    a_accept_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("pixel transfer did not raise busy");

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Mandelbrot escape-time engine: directed views, then random ones.
module testbench;
    import mbe_pkg::*;

    // Matches the engine's default dimension clamp.
    localparam int     DIM_LIMIT     = 4096;
    localparam int     IDLE_MAX      = 13;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_ITEMS   = 130;
    // Longest pixel in the random part: its mapping plus iterating up to the limit of 600.
    localparam int     TAIL_CYCLES   = 1400;
    // Allow several times the length of the slowest legal run.
    localparam longint CYCLE_LIMIT   = 8_000_000;
    localparam longint Q_TOP         = 64'sd2147483647;
    localparam longint Q_BOTTOM      = -64'sd2147483648;
    // Index 7 names no register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum logic [1:0]
    {
        CMD_PIXEL,
        CMD_WRITE,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t             kind;
        logic [PIX_W-1:0]      x;
        logic [PIX_W-1:0]      y;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [7:0]            gap;
    } stim_cmd_t;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic [PIX_W-1:0]      pixel_x    = '0;
    logic [PIX_W-1:0]      pixel_y    = '0;
    logic                  done;
    logic [COUNT_W-1:0]    escape_count;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    // Commands waiting for the driver: pixels, register writes and drain points.
    stim_cmd_t          pending_cmds[$];
    int unsigned        idle_limit = IDLE_MAX;

    // Predicted escape counts, one per accepted pixel, in order of transfer.
    logic [COUNT_W-1:0] expected_counts[$];
    // sent_count and got_count change only by nonblocking assignment, so each
    // side reads the other's value from before the edge.
    int unsigned        sent_count = 0;
    int unsigned        got_count  = 0;
    int unsigned        fail_count = 0;
    longint             cycle_count = 0;

    // The driver's own copy of the view registers.
    mbe_cfg_t           view_regs;
    stim_cmd_t          current;
    logic               holding = 1'b0;
    int unsigned        wait_left = 0;
    int unsigned        accepted_total = 0;
    logic               start_next;
    logic               write_next;

    always #6 clk = ~clk;

    mandelbrot_escape_iteration #(
        .MAX_DIM      (DIM_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .done         (done),
        .escape_count (escape_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------
    // Escape-count predictor
    // ------------------------------------------------------------------

    function automatic longint saturate_q(input longint v);
        if (v > Q_TOP)
        begin
            return Q_TOP;
        end
        if (v < Q_BOTTOM)
        begin
            return Q_BOTTOM;
        end
        return v;
    endfunction

    // Map one pixel coordinate onto its axis: the quotient truncates toward zero,
    // the sum with the edge saturates. A zero dimension counts as one, an oversized
    // one as the clamp.
    function automatic longint map_coord(input logic [PIX_W-1:0] pix,
                                         input logic [DIM_W-1:0] dim,
                                         input logic [Q_W-1:0]   lo,
                                         input logic [Q_W-1:0]   hi);
        longint lo_s;
        longint span;
        longint divisor;
        lo_s = longint'(signed'(lo));
        span = longint'(signed'(hi)) - lo_s;
        if (dim == '0)
        begin
            divisor = 1;
        end
        else if (dim > DIM_LIMIT)
        begin
            divisor = DIM_LIMIT;
        end
        else
        begin
            divisor = longint'(dim);
        end
        return saturate_q(lo_s + (span * longint'(pix)) / divisor);
    endfunction

    function automatic logic [COUNT_W-1:0] escape_count_for(input mbe_cfg_t         v,
                                                            input logic [PIX_W-1:0] px,
                                                            input logic [PIX_W-1:0] py);
        longint              c_re;
        longint              c_im;
        longint              z_re;
        longint              z_im;
        longint              re_sq;
        longint              im_sq;
        longint              re_next;
        longint unsigned     mag_sq;
        int unsigned         steps;
        c_re  = map_coord(px, v.image_width, v.min_r, v.max_r);
        c_im  = map_coord(py, v.image_height, v.min_i, v.max_i);
        z_re  = 0;
        z_im  = 0;
        steps = 0;
        while (steps < v.iteration_limit)
        begin
            re_sq  = z_re * z_re;
            im_sq  = z_im * z_im;
            // The sum of squares can reach 2^63, so compare it unsigned.
            mag_sq = longint'(re_sq) + longint'(im_sq);
            if (mag_sq >= ESCAPE_Q56)
            begin
                break;
            end
            // Arithmetic shifts give the floor the fixed-point update calls for.
            re_next = saturate_q(((re_sq - im_sq) >>> 28) + c_re);
            z_im    = saturate_q(((z_re * z_im) >>> 27) + c_im);
            z_re    = re_next;
            steps++;
        end
        return steps[COUNT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic queue_pixel(input int unsigned x, input int unsigned y);
        stim_cmd_t c;
        c       = '0;
        c.kind  = CMD_PIXEL;
        c.x     = x[PIX_W-1:0];
        c.y     = y[PIX_W-1:0];
        c.gap   = 8'($urandom_range(0, idle_limit));
        pending_cmds.push_back(c);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0]  index,
                               input logic [CFG_DATA_W-1:0] data);
        stim_cmd_t c;
        c       = '0;
        c.kind  = CMD_WRITE;
        c.index = index;
        c.data  = data;
        c.gap   = 8'($urandom_range(0, idle_limit));
        pending_cmds.push_back(c);
    endtask

    // Hold the sender until every transfer so far has its result.
    task automatic queue_drain();
        stim_cmd_t c;
        c      = '0;
        c.kind = CMD_DRAIN;
        pending_cmds.push_back(c);
    endtask

    // Dimension write word: mostly small images, now and then one, the clamp,
    // zero or any 13-bit value; the bits above the field are noise.
    function automatic logic [CFG_DATA_W-1:0] draw_dim_word();
        logic [CFG_DATA_W-1:0] word;
        int unsigned           pick;
        word = $urandom;
        pick = $urandom_range(0, 19);
        if (pick < 15)
        begin
            word[DIM_W-1:0] = DIM_W'($urandom_range(1, 400));
        end
        else if (pick == 15)
        begin
            word[DIM_W-1:0] = DIM_W'(1);
        end
        else if (pick == 16)
        begin
            word[DIM_W-1:0] = DIM_W'(DIM_LIMIT);
        end
        else if (pick == 17)
        begin
            word[DIM_W-1:0] = '0;
        end
        return word;
    endfunction

    // Number of pixels the dimension in a write word really spans.
    function automatic int unsigned usable_dim(input logic [CFG_DATA_W-1:0] word);
        int unsigned d;
        d = word[DIM_W-1:0];
        if (d == 0)
        begin
            d = 1;
        end
        else if (d > DIM_LIMIT)
        begin
            d = DIM_LIMIT;
        end
        return d;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // ------------------------------------------------------------------
    // Driver: pops commands, inserts the drawn idle gap, raises start or
    // cfg_valid and holds it until the transfer. Each transfer updates the
    // register copy or records the prediction for the pixel.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start          <= 1'b0;
            cfg_valid      <= 1'b0;
            holding        = 1'b0;
            wait_left      = 0;
            accepted_total = 0;
            sent_count     <= 0;
            view_regs.min_r           = RST_MIN_R;
            view_regs.max_r           = RST_MAX_R;
            view_regs.min_i           = RST_MIN_I;
            view_regs.max_i           = RST_MAX_I;
            view_regs.image_width     = RST_IMG_WIDTH;
            view_regs.image_height    = RST_IMG_HEIGHT;
            view_regs.iteration_limit = RST_ITER_LIMIT;
        end
        else
        begin
            start_next = start;
            write_next = cfg_valid;

            // Pixel transfer: predict with the registers as they stand now.
            if (start && !busy)
            begin
                expected_counts.push_back(escape_count_for(view_regs, pixel_x, pixel_y));
                accepted_total++;
                start_next = 1'b0;
                holding    = 1'b0;
            end

            // Register transfer: keep the copy in step, with the same field widths.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MIN_R:      view_regs.min_r           = cfg_data;
                    REG_MAX_R:      view_regs.max_r           = cfg_data;
                    REG_MIN_I:      view_regs.min_i           = cfg_data;
                    REG_MAX_I:      view_regs.max_i           = cfg_data;
                    REG_IMG_WIDTH:  view_regs.image_width     = cfg_data[DIM_W-1:0];
                    REG_IMG_HEIGHT: view_regs.image_height    = cfg_data[DIM_W-1:0];
                    REG_ITER_LIMIT: view_regs.iteration_limit = cfg_data[COUNT_W-1:0];
                    default:        ;
                endcase
                write_next = 1'b0;
                holding    = 1'b0;
            end

            if (!holding && pending_cmds.size() != 0)
            begin
                current   = pending_cmds.pop_front();
                holding   = 1'b1;
                wait_left = current.gap;
            end

            if (holding && !start_next && !write_next)
            begin
                if (current.kind == CMD_DRAIN)
                begin
                    // Release once the monitor has caught up with every transfer.
                    if (got_count == accepted_total)
                    begin
                        holding = 1'b0;
                    end
                end
                else if (wait_left != 0)
                begin
                    wait_left--;
                end
                else if (current.kind == CMD_PIXEL)
                begin
                    start_next = 1'b1;
                    pixel_x    <= current.x;
                    pixel_y    <= current.y;
                end
                else
                begin
                    write_next = 1'b1;
                    cfg_index  <= current.index;
                    cfg_data   <= current.data;
                end
            end

            // One assignment per edge, so a start held for back-to-back pixels stays high.
            start      <= start_next;
            cfg_valid  <= write_next;
            sent_count <= accepted_total;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each done strobe carries one result; match it against the
    // oldest prediction not yet consumed.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            got_count <= 0;
        end
        else if (done)
        begin
            if (got_count >= sent_count)
            begin
                report_mismatch($sformatf("result %0d with no pixel outstanding",
                                          escape_count));
            end
            else
            begin
                if (escape_count !== expected_counts[got_count])
                begin
                    report_mismatch($sformatf("pixel %0d: escape_count %0d, predicted %0d",
                                              got_count, escape_count,
                                              expected_counts[got_count]));
                end
                got_count <= got_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run if it goes far past the slowest correct one.
    // ------------------------------------------------------------------

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus plan, then end of run
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        longint                lo_r;
        longint                lo_i;
        longint                span_r;
        longint                span_i;
        longint                hi_r;
        longint                hi_i;
        logic [CFG_DATA_W-1:0] cfg_word;
        int unsigned           w;
        int unsigned           h;
        int unsigned           lim;
        int unsigned           pick;

        // Reset view: corners, center of the image, a point inside the set and
        // coordinates far past the image edges.
        queue_pixel(0, 0);
        queue_pixel(639, 479);
        queue_pixel(320, 240);
        queue_pixel(0, 240);
        queue_pixel(639, 0);
        queue_pixel(160, 120);
        queue_pixel(480, 360);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);
        queue_pixel(0, 4095);
        queue_pixel(2048, 2048);

        // Zero limit: every pixel reports zero.
        queue_drain();
        queue_write(REG_ITER_LIMIT, 32'h0000_0000);
        queue_pixel(320, 240);
        queue_pixel(4095, 4095);

        // Widest possible view with zero dimensions: the mapping saturates.
        queue_drain();
        queue_write(REG_MIN_R, 32'h8000_0000);
        queue_write(REG_MAX_R, 32'h7FFF_FFFF);
        queue_write(REG_MIN_I, 32'h8000_0000);
        queue_write(REG_MAX_I, 32'h7FFF_FFFF);
        queue_write(REG_IMG_WIDTH, 32'h0000_0000);
        queue_write(REG_IMG_HEIGHT, 32'h0000_0000);
        queue_write(REG_ITER_LIMIT, 32'h0000_0014);
        queue_pixel(0, 0);
        queue_pixel(1, 1);
        queue_pixel(4095, 4095);
        queue_pixel(4095, 0);

        // Oversized width with noise above the field, height exactly at the clamp,
        // a view of [-2, 2] on both axes: c = -2 sits right on the escape circle.
        queue_drain();
        queue_write(REG_IMG_WIDTH, 32'hFFFF_FFFF);
        queue_write(REG_IMG_HEIGHT, 32'h0000_1000);
        queue_write(REG_MIN_R, 32'hE000_0000);
        queue_write(REG_MAX_R, 32'h2000_0000);
        queue_write(REG_MIN_I, 32'hE000_0000);
        queue_write(REG_MAX_I, 32'h2000_0000);
        queue_write(REG_ITER_LIMIT, 32'h0000_00FF);
        queue_pixel(0, 2048);
        queue_pixel(2048, 2048);
        queue_pixel(4095, 4095);
        queue_pixel(1024, 3072);

        // Write to an unused index, then collapse the view onto c = 0 with the
        // largest limit: the pixel runs the full count.
        queue_drain();
        queue_write(REG_UNUSED, 32'hFFFF_FFFF);
        queue_write(REG_MIN_R, 32'h0000_0000);
        queue_write(REG_MAX_R, 32'h0000_0000);
        queue_write(REG_MIN_I, 32'h0000_0000);
        queue_write(REG_MAX_I, 32'h0000_0000);
        queue_write(REG_ITER_LIMIT, 32'h0000_FFFF);
        queue_pixel(5, 7);
        // Same limit, c = 1.0: escapes after two steps.
        queue_drain();
        queue_write(REG_MIN_R, 32'h1000_0000);
        queue_pixel(0, 0);

        // Random phases: a new view each time, drained before the writes.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            queue_drain();
            // Some phases run with no idle cycles at all.
            idle_limit = ($urandom_range(0, 9) < 3) ? 0 : IDLE_MAX;

            if ($urandom_range(0, 3) != 0)
            begin
                // Window over the set, from wide views down to deep zooms.
                lo_r   = -64'sd536870912 + longint'($urandom_range(0, 671088640));
                lo_i   = -64'sd322122547 + longint'($urandom_range(0, 536870912));
                span_r = (longint'($urandom_range(1, 12)) << 26) >>> $urandom_range(0, 14);
                span_i = (longint'($urandom_range(1, 12)) << 26) >>> $urandom_range(0, 14);
                hi_r   = lo_r + span_r;
                hi_i   = lo_i + span_i;
                queue_write(REG_MIN_R, lo_r[31:0]);
                queue_write(REG_MAX_R, hi_r[31:0]);
                queue_write(REG_MIN_I, lo_i[31:0]);
                queue_write(REG_MAX_I, hi_i[31:0]);
            end
            else
            begin
                // Any edges at all, reversed ranges included.
                queue_write(REG_MIN_R, $urandom);
                queue_write(REG_MAX_R, $urandom);
                queue_write(REG_MIN_I, $urandom);
                queue_write(REG_MAX_I, $urandom);
            end

            cfg_word = draw_dim_word();
            w        = usable_dim(cfg_word);
            queue_write(REG_IMG_WIDTH, cfg_word);
            cfg_word = draw_dim_word();
            h        = usable_dim(cfg_word);
            queue_write(REG_IMG_HEIGHT, cfg_word);

            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                lim = 0;
            end
            else if (pick < 8)
            begin
                lim = $urandom_range(1, 255);
            end
            else
            begin
                lim = $urandom_range(256, 600);
            end
            cfg_word          = $urandom;
            cfg_word[15:0]    = lim[15:0];
            queue_write(REG_ITER_LIMIT, cfg_word);

            if ($urandom_range(0, 3) == 0)
            begin
                queue_write(REG_UNUSED, $urandom);
            end

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // Now and then hold off until the engine is empty.
                if ($urandom_range(0, 49) == 0)
                begin
                    queue_drain();
                end
                if ($urandom_range(0, 9) == 0)
                begin
                    queue_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                end
                else
                begin
                    queue_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
                end
            end
        end

        // Release reset; the driver then starts on its own.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the driver to run dry and every result to come in.
        do
        begin
            @(negedge clk);
        end
        while (pending_cmds.size() != 0 || holding || start || cfg_valid ||
               got_count != sent_count);

        // Give a stray strobe time to show up.
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
